// ===== rtl/msb_pkg.sv =====
// ----------------------------------------------------------------------------
// msb_pkg
// shared types, message rom and morse code tables for the beacon sequencer
// ----------------------------------------------------------------------------
package msb_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned ELEM_W    = 3;
    localparam int unsigned ROM_DEPTH = 16;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT        = 3'd0,
        REG_DASH       = 3'd1,
        REG_ELEM_GAP   = 3'd2,
        REG_LETTER_GAP = 3'd3,
        REG_WORD_GAP   = 3'd4
    } t_cfg_idx;

    // register reset values
    localparam logic [CFG_DAT_W-1:0] DOT_RST        = 16'd100;
    localparam logic [CFG_DAT_W-1:0] DASH_RST       = 16'd300;
    localparam logic [CFG_DAT_W-1:0] ELEM_GAP_RST   = 16'd100;
    localparam logic [CFG_DAT_W-1:0] LETTER_GAP_RST = 16'd300;
    localparam logic [CFG_DAT_W-1:0] WORD_GAP_RST   = 16'd700;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] dot_ms;
        logic [CFG_DAT_W-1:0] dash_ms;
        logic [CFG_DAT_W-1:0] element_gap_ms;
        logic [CFG_DAT_W-1:0] letter_gap_ms;
        logic [CFG_DAT_W-1:0] word_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  char_pos;
        logic [ELEM_W-1:0] element_pos;
        logic              lit;
    } t_seq_status;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_Z     = 8'h5A;

    // "BOOTLOADER " then zero padding, which reads as unknown characters
    typedef logic [7:0] t_char_rom [ROM_DEPTH];
    localparam t_char_rom MSG_ROM = '{
        8'h42, 8'h4F, 8'h4F, 8'h54, 8'h4C, 8'h4F, 8'h41, 8'h44,
        8'h45, 8'h52, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // element count per letter, and dash pattern (bit i set = element i is a dash)
    typedef logic [2:0] t_len_tab  [26];
    typedef logic [3:0] t_dash_tab [26];
    localparam t_len_tab CODE_LEN = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam t_dash_tab CODE_DASH = '{
        4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2, 4'h3,
        4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
    };

    typedef enum logic [1:0] {
        CK_LETTER,
        CK_SPACE,
        CK_OTHER
    } t_char_kind;

    typedef struct packed {
        t_char_kind kind;
        logic [2:0] len;
        logic [3:0] dash;
    } t_code_info;

    function automatic t_code_info char_code(input logic [7:0] ch);
        t_code_info info;
        logic [7:0] ofs;
        info.kind = CK_OTHER;
        info.len  = 3'd0;
        info.dash = 4'h0;
        ofs       = ch - ASCII_A;
        if (ch == ASCII_SPACE) begin
            info.kind = CK_SPACE;
        end else if (ch >= ASCII_A && ch <= ASCII_Z) begin
            info.kind = CK_LETTER;
            info.len  = CODE_LEN[ofs[4:0]];
            info.dash = CODE_DASH[ofs[4:0]];
        end
        return info;
    endfunction

endpackage

// ===== rtl/msb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// msb_cfg_regs
// timing registers written through the config port
// ----------------------------------------------------------------------------
module msb_cfg_regs
    import msb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [CFG_DAT_W-1:0] i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_ms         <= DOT_RST;
            r_cfg.dash_ms        <= DASH_RST;
            r_cfg.element_gap_ms <= ELEM_GAP_RST;
            r_cfg.letter_gap_ms  <= LETTER_GAP_RST;
            r_cfg.word_gap_ms    <= WORD_GAP_RST;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                REG_DOT:        r_cfg.dot_ms         <= i_wr_data;
                REG_DASH:       r_cfg.dash_ms        <= i_wr_data;
                REG_ELEM_GAP:   r_cfg.element_gap_ms <= i_wr_data;
                REG_LETTER_GAP: r_cfg.letter_gap_ms  <= i_wr_data;
                REG_WORD_GAP:   r_cfg.word_gap_ms    <= i_wr_data;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/msb_seq_core.sv =====
// ----------------------------------------------------------------------------
// msb_seq_core
// sequencer state and single-pass poll logic
// ----------------------------------------------------------------------------
module msb_seq_core
    import msb_pkg::*;
#(
    parameter int unsigned MSG_LEN = 11
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_busy_req,
    input  t_cfg              i_cfg,
    output logic              o_led_on,
    output t_seq_status       o_status
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MSG_LEN);

    logic [POS_W-1:0]  r_char_pos,    n_char_pos;
    logic [ELEM_W-1:0] r_element_pos, n_element_pos;
    logic              r_lit,         n_lit;
    logic [TIME_W-1:0] r_mark_time,   n_mark_time;

    t_code_info        w_info;
    logic [TIME_W-1:0] w_elapsed;
    logic [CFG_DAT_W-1:0] w_thr;
    logic              w_ge;
    logic              w_msg_end;
    logic              w_led;

    assign w_info    = char_code(MSG_ROM[r_char_pos]);
    assign w_elapsed = i_now_ms - r_mark_time;
    assign w_msg_end = (r_char_pos >= LAST_POS);
    assign w_ge      = (w_elapsed >= {{(TIME_W-CFG_DAT_W){1'b0}}, w_thr});

    // pick the one threshold that the current state compares against
    always_comb begin
        w_thr = i_cfg.word_gap_ms;
        if (!w_msg_end && w_info.kind == CK_LETTER) begin
            if (r_element_pos >= w_info.len) begin
                w_thr = i_cfg.letter_gap_ms;
            end else if (!r_lit) begin
                w_thr = i_cfg.element_gap_ms;
            end else if (w_info.dash[r_element_pos[1:0]]) begin
                w_thr = i_cfg.dash_ms;
            end else begin
                w_thr = i_cfg.dot_ms;
            end
        end
    end

    always_comb begin
        n_char_pos    = r_char_pos;
        n_element_pos = r_element_pos;
        n_lit         = r_lit;
        n_mark_time   = r_mark_time;
        w_led         = 1'b0;
        if (w_msg_end) begin
            if (w_ge) begin
                n_char_pos    = '0;
                n_element_pos = '0;
                n_lit         = 1'b0;
                n_mark_time   = i_now_ms;
            end
        end else begin
            case (w_info.kind)
                CK_SPACE: begin
                    if (w_ge) begin
                        n_char_pos    = r_char_pos + 1'b1;
                        n_element_pos = '0;
                        n_lit         = 1'b0;
                        n_mark_time   = i_now_ms;
                    end
                end
                CK_LETTER: begin
                    if (r_element_pos >= w_info.len) begin
                        if (w_ge) begin
                            n_char_pos    = r_char_pos + 1'b1;
                            n_element_pos = '0;
                            n_lit         = 1'b0;
                            n_mark_time   = i_now_ms;
                        end
                    end else if (!r_lit) begin
                        // first element lights at once, later ones after the gap
                        if (r_element_pos == '0 || w_ge) begin
                            n_lit       = 1'b1;
                            n_mark_time = i_now_ms;
                            w_led       = 1'b1;
                        end
                    end else if (w_ge) begin
                        n_lit         = 1'b0;
                        n_element_pos = r_element_pos + 1'b1;
                        n_mark_time   = i_now_ms;
                    end else begin
                        w_led = 1'b1;
                    end
                end
                default: begin
                    // unknown character, skip in one poll
                    n_char_pos    = r_char_pos + 1'b1;
                    n_element_pos = '0;
                    n_lit         = 1'b0;
                    n_mark_time   = i_now_ms;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos    <= '0;
            r_element_pos <= '0;
            r_lit         <= 1'b0;
            r_mark_time   <= '0;
        end else if (i_step && !i_busy_req) begin
            r_char_pos    <= n_char_pos;
            r_element_pos <= n_element_pos;
            r_lit         <= n_lit;
            r_mark_time   <= n_mark_time;
        end
    end

    assign o_led_on             = w_led && !i_busy_req;
    assign o_status.char_pos    = r_char_pos;
    assign o_status.element_pos = r_element_pos;
    assign o_status.lit         = r_lit;

endmodule

// ===== rtl/morse_beacon_sequencer.sv =====
// ----------------------------------------------------------------------------
// morse_beacon_sequencer
// blinks a fixed message in morse code, one led result per time poll
// ----------------------------------------------------------------------------
// path: a poll beat lands in the input register; once the result slot is
//   free, the poll logic writes the state and the result register together
// throughput: one poll per cycle unless the led channel stalls; the state
//   update is a single pass of logic
// reset: synchronous active low, clears the sequence to the first character,
//   loads the default timings and empties both pipeline registers
module morse_beacon_sequencer
    import msb_pkg::*;
#(
    parameter int unsigned MSG_LEN = 11
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // poll channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_busy_req,
    // led channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_led_on,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // input register
    logic              r_in_valid;
    logic [TIME_W-1:0] r_now_ms;
    logic              r_busy_req;
    // result register
    logic              r_out_valid;
    logic              r_led_on;

    logic        w_out_free;
    logic        w_advance;
    logic        w_in_fire;
    logic        w_core_led;
    t_cfg        w_cfg;
    t_seq_status w_status;

    // result register frees when empty or taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // a held poll beat moves through the logic whenever the result slot is free
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    msb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    msb_seq_core #(
        .MSG_LEN (MSG_LEN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_now_ms   (r_now_ms),
        .i_busy_req (r_busy_req),
        .i_cfg      (w_cfg),
        .o_led_on   (w_core_led),
        .o_status   (w_status)
    );

    // input register, control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register, payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_now_ms   <= i_now_ms;
            r_busy_req <= i_busy_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_led_on <= w_core_led;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_on    = r_led_on;

    // a busy poll leaves the led dark
    a_busy_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_busy_req) |=> (r_out_valid && !r_led_on))
        else $error("busy poll produced a lit led");

    // a busy poll freezes the sequence
    a_busy_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_busy_req) |=> ($stable(w_status)))
        else $error("busy poll changed sequencer state");

    // outside busy, the led result always matches the lit state just written
    a_led_tracks_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_busy_req) |=> (r_led_on == w_status.lit))
        else $error("led result disagrees with lit state");

    // element index never runs past the longest letter
    a_elem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.element_pos <= 3'd4))
        else $error("element index out of range");

endmodule

// ===== tb/sv/tb_morse_beacon_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_morse_beacon_sequencer
// self-checking bench for the morse beacon sequencer: a table of directed
// polls walks the first letter and the time wrap, then random polls run
// through several timing settings while both channels stall at random; every
// led beat is compared with an in-bench model of the blink sequence
// ----------------------------------------------------------------------------
module tb_morse_beacon_sequencer
    import msb_pkg::*;
();

    localparam int MSG_CHARS       = 11;
    localparam int CLK_HALF        = 6;
    localparam int PIPE_LAT        = 2;        // poll beat in to led beat out
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int LIMIT_CYCLES    = 100000;
    localparam int MAX_REPORTS     = 40;

    localparam logic LED_DARK = 1'b0;
    localparam logic LED_LIT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IDX_MAX = {CFG_IDX_W{1'b1}};

    // beacon text and morse tables, kept here independent of the rtl package
    localparam logic [7:0] CHAR_SPACE = " ";
    localparam logic [7:0] CHAR_A     = "A";
    localparam logic [7:0] CHAR_Z     = "Z";
    localparam logic [7:0] BEACON_TEXT [16] = '{
        "B", "O", "O", "T", "L", "O", "A", "D", "E", "R", " ",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    // element count per letter, and dash mask (bit i set = element i is a dash)
    localparam logic [2:0] MORSE_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] MORSE_DASH [26] = '{
        4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2, 4'h3,
        4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
    };

    // one directed poll; typed rows carry the led value to expect
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              busy;
        logic              typed;
        logic              led;
    } t_poll_row;

    // from reset the first letter is B: dash dot dot dot
    localparam t_poll_row DIRECTED_POLLS [18] = '{
        '{32'd0,          1'b1, 1'b1, LED_DARK},  // busy forces dark, nothing moves
        '{32'd0,          1'b0, 1'b1, LED_LIT },  // first element lights at once
        '{32'd299,        1'b0, 1'b1, LED_LIT },  // dash not yet over
        '{32'd300,        1'b1, 1'b1, LED_DARK},  // busy right at the dash end
        '{32'd300,        1'b0, 1'b1, LED_DARK},  // dash ends
        '{32'd399,        1'b0, 1'b1, LED_DARK},  // element gap one short
        '{32'd400,        1'b0, 1'b1, LED_LIT },  // second element lights
        '{32'd500,        1'b0, 1'b0, LED_DARK},
        '{32'd600,        1'b0, 1'b0, LED_DARK},
        '{32'd700,        1'b0, 1'b0, LED_DARK},
        '{32'hFFFF_FFF0,  1'b0, 1'b0, LED_DARK},  // last element starts near the top
        '{32'hFFFF_FFFF,  1'b1, 1'b0, LED_DARK},
        '{32'h0000_0053,  1'b0, 1'b0, LED_DARK},  // elapsed across the wrap, one short
        '{32'h0000_0054,  1'b0, 1'b0, LED_DARK},  // dot ends across the wrap
        '{32'h0000_017F,  1'b0, 1'b0, LED_DARK},  // letter gap one short
        '{32'h0000_0180,  1'b0, 1'b0, LED_DARK},  // on to the next letter
        '{32'hFFFF_FFFF,  1'b0, 1'b0, LED_DARK},
        '{32'h0000_012B,  1'b0, 1'b0, LED_DARK}   // dash ends across the wrap
    };

    // dut ports, the inputs all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [TIME_W-1:0]    i_now_ms    = '0;
    logic                 i_busy_req  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_led_on;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // model of the sequencer: timings indexed by register, plus position state
    logic [CFG_DAT_W-1:0] timing [5] = '{16'd100, 16'd300, 16'd100, 16'd300, 16'd700};
    logic [POS_W-1:0]     seq_char   = '0;
    logic [ELEM_W-1:0]    seq_elem   = '0;
    logic                 seq_lit    = 1'b0;
    logic [TIME_W-1:0]    seq_mark   = '0;

    logic led_due_q [$];   // led values still owed by the dut, oldest first
    int   mismatch_count = 0;
    bit   stall_on       = 1'b0;   // receiver may drop ready in bursts
    int   stall_left     = 0;

    morse_beacon_sequencer #(
        .MSG_LEN     (MSG_CHARS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_now_ms    (i_now_ms),
        .i_busy_req  (i_busy_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_led_on    (o_led_on),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // drop back to the start of the current character's successor
    function automatic void skip_char(input logic [TIME_W-1:0] now);
        seq_char = seq_char + 1'b1;
        seq_elem = '0;
        seq_lit  = 1'b0;
        seq_mark = now;
    endfunction

    // advance the model by one poll and return the led value it shows
    function automatic logic predict_led(input logic [TIME_W-1:0] now, input logic busy);
        logic [TIME_W-1:0]    elapsed;
        logic [7:0]           ch;
        logic [4:0]           letter;
        logic [CFG_DAT_W-1:0] hold;
        elapsed = now - seq_mark;
        if (busy) begin
            return LED_DARK;
        end
        // past the text: word gap, then back to the first character
        if (seq_char >= MSG_CHARS) begin
            if (elapsed >= timing[REG_WORD_GAP]) begin
                seq_char = '0;
                seq_elem = '0;
                seq_lit  = 1'b0;
                seq_mark = now;
            end
            return LED_DARK;
        end
        ch = BEACON_TEXT[seq_char];
        if (ch == CHAR_SPACE) begin
            if (elapsed >= timing[REG_WORD_GAP]) begin
                skip_char(now);
            end
            return LED_DARK;
        end
        // anything not a letter is passed over in one poll
        if (ch < CHAR_A || ch > CHAR_Z) begin
            skip_char(now);
            return LED_DARK;
        end
        letter = 5'(ch - CHAR_A);
        if (seq_elem >= MORSE_LEN[letter]) begin
            if (elapsed >= timing[REG_LETTER_GAP]) begin
                skip_char(now);
            end
            return LED_DARK;
        end
        if (!seq_lit) begin
            if (seq_elem != 0 && elapsed < timing[REG_ELEM_GAP]) begin
                return LED_DARK;
            end
            seq_lit  = 1'b1;
            seq_mark = now;
            return LED_LIT;
        end
        hold = MORSE_DASH[letter][seq_elem[1:0]] ? timing[REG_DASH] : timing[REG_DOT];
        if (elapsed >= hold) begin
            seq_lit  = 1'b0;
            seq_elem = seq_elem + 1'b1;
            seq_mark = now;
            return LED_DARK;
        end
        return LED_LIT;
    endfunction

    // present one poll beat, hold it until taken, then log what it should show
    task automatic send_poll(input logic [TIME_W-1:0] now, input logic busy,
                             input logic typed, input logic typed_led);
        logic led;
        i_in_valid <= 1'b1;
        i_now_ms   <= now;
        i_busy_req <= busy;
        do @(posedge i_clk); while (!o_in_ready);
        led = predict_led(now, busy);
        led_due_q.push_back(typed ? typed_led : led);
    endtask

    // one register write beat; the caller lowers valid after its last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= REG_WORD_GAP) begin
            timing[idx] = data;
        end
    endtask

    task automatic load_timings(input logic [CFG_DAT_W-1:0] dot, dash, egap, lgap, wgap,
                                input bit spare);
        cfg_write(REG_DOT, dot);
        cfg_write(REG_DASH, dash);
        cfg_write(REG_ELEM_GAP, egap);
        cfg_write(REG_LETTER_GAP, lgap);
        cfg_write(REG_WORD_GAP, wgap);
        // indexes past the last register must leave every timing alone
        if (spare) begin
            for (int k = REG_WORD_GAP + 1; k <= REG_IDX_MAX; k++) begin
                cfg_write(CFG_IDX_W'(k), CFG_DAT_W'($urandom_range(0, 65535)));
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // stop polling, let every owed led beat arrive, then let the pipe settle
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (led_due_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // mostly short timings so the text loops often, now and then any value
    function automatic logic [CFG_DAT_W-1:0] rand_timing(input int lo);
        case ($urandom_range(0, 3))
            0:       return CFG_DAT_W'($urandom_range(lo, 65535));
            1:       return CFG_DAT_W'(lo);
            default: return CFG_DAT_W'($urandom_range(lo, 400));
        endcase
    endfunction

    // led side: random ready bursts, and every beat checked against the oldest owed value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (led_due_q.size() == 0) begin
                report_mismatch($sformatf("led beat %0b with nothing owed", o_led_on));
            end else begin
                if (o_led_on !== led_due_q[0]) begin
                    report_mismatch($sformatf("led_on %0b, expected %0b",
                                              o_led_on, led_due_q[0]));
                end
                void'(led_due_q.pop_front());
            end
        end
        if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] poll_ms;
        logic              busy;
        bit                gaps_on;
        int                span;
        int                mode;
        int                pick;
        poll_ms = '0;
        gaps_on = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the first letter with the reset timings
        for (int n = 0; n < $size(DIRECTED_POLLS); n++) begin
            send_poll(DIRECTED_POLLS[n].now, DIRECTED_POLLS[n].busy,
                      DIRECTED_POLLS[n].typed, DIRECTED_POLLS[n].led);
            poll_ms = DIRECTED_POLLS[n].now;
        end

        // random phases: reset timings, all minimum, all maximum, then mixed
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                settle_idle();
                case (ph)
                    1:       load_timings(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
                    2:       load_timings('1, '1, '1, '1, '1, 1'b1);
                    default: load_timings(rand_timing(1), rand_timing(1), rand_timing(0),
                                          rand_timing(0), rand_timing(0), ph == 3);
                endcase
            end
            // the last phase runs at full rate on both sides
            gaps_on  = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stall_on <= gaps_on;
            span = 1;
            foreach (timing[k]) begin
                if (int'(timing[k]) + 1 > span) span = int'(timing[k]) + 1;
            end

            repeat (ITEMS_PER_PHASE) begin
                if (gaps_on && $urandom_range(0, 5) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
                mode = $urandom_range(0, 99);
                if (mode < 60) begin
                    // ordinary forward step, usually enough to move one state
                    poll_ms = poll_ms + TIME_W'($urandom_range(0, span + span / 2));
                end else if (mode < 80) begin
                    // land on, or one either side of, a timing edge
                    pick    = $urandom_range(0, 4);
                    poll_ms = seq_mark + TIME_W'(timing[pick])
                            + TIME_W'($urandom_range(0, 2)) - 1'b1;
                end else if (mode >= 90) begin
                    // jump anywhere, wrapping backward as often as forward
                    poll_ms = $urandom;
                end
                busy = ($urandom_range(0, 9) == 0);
                send_poll(poll_ms, busy, 1'b0, LED_DARK);
            end
        end

        settle_idle();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hard stop if a handshake never completes
    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/msb_pkg.sv
rtl/msb_cfg_regs.sv
rtl/msb_seq_core.sv
rtl/morse_beacon_sequencer.sv
tb/sv/tb_morse_beacon_sequencer.sv
